FILE: hdl/cuc_pkg.sv
// Shared types, constants and codon lookup tables for the codon usage counter.
`timescale 1ns / 1ps
package cuc_pkg;

  localparam int CODON_COUNT        = 64;
  localparam int AMINO_COUNT        = 22;
  localparam int COUNT_WIDTH_DEF    = 32;
  localparam int POSITION_WIDTH_DEF = 24;
  localparam int OUT_COUNT_WIDTH    = 32;
  localparam int OUT_POS_WIDTH      = 24;

  typedef enum logic [1:0] {
    OP_COUNT      = 2'd0,
    OP_READ_CODON = 2'd1,
    OP_READ_AMINO = 2'd2,
    OP_CLEAR      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BASE_A = 2'd0,
    BASE_C = 2'd1,
    BASE_G = 2'd2,
    BASE_T = 2'd3
  } base_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] first_base;
    logic [7:0] second_base;
    logic [7:0] third_base;
    logic       start_of_sequence;
    logic [5:0] table_index;
  } in_item_t;

  typedef struct packed {
    logic                       codon_recognized;
    logic [5:0]                 codon_index;
    logic [4:0]                 amino_acid_index;
    logic [OUT_POS_WIDTH-1:0]   position;
    logic [OUT_COUNT_WIDTH-1:0] count_value;
    logic                       index_valid;
  } out_item_t;

  typedef struct packed {
    logic       recognized;
    logic [5:0] codon_index;
    logic [4:0] amino_index;
  } codon_info_t;

  typedef struct packed {
    logic rd_en;
    logic upd_en;
    logic clr_en;
  } bank_ctl_t;

  // Reference index of each codon, addressed by {first, second, third} base codes.
  localparam logic [5:0] CODON_REF [0:63] = '{
    6'd21, 6'd30, 6'd22, 6'd31,  6'd48, 6'd49, 6'd50, 6'd51,
    6'd38, 6'd59, 6'd39, 6'd60,  6'd18, 6'd19, 6'd29, 6'd20,
    6'd36, 6'd16, 6'd37, 6'd17,  6'd32, 6'd33, 6'd34, 6'd35,
    6'd40, 6'd41, 6'd42, 6'd43,  6'd23, 6'd24, 6'd25, 6'd26,
    6'd8,  6'd6,  6'd9,  6'd7,   6'd0,  6'd1,  6'd2,  6'd3,
    6'd12, 6'd13, 6'd14, 6'd15,  6'd52, 6'd53, 6'd54, 6'd55,
    6'd61, 6'd57, 6'd62, 6'd58,  6'd44, 6'd45, 6'd46, 6'd47,
    6'd63, 6'd4,  6'd56, 6'd5,   6'd27, 6'd10, 6'd28, 6'd11
  };

  // Amino-acid index of each codon in reference order; serine pair AGC/AGT
  // is its own index, stops share the last one.
  localparam logic [4:0] AMINO_OF [0:63] = '{
    5'd0,  5'd0,  5'd0,  5'd0,  5'd1,  5'd1,  5'd2,  5'd2,  5'd3,  5'd3,
    5'd4,  5'd4,  5'd5,  5'd5,  5'd5,  5'd5,  5'd6,  5'd6,  5'd7,  5'd7,
    5'd7,  5'd8,  5'd8,  5'd9,  5'd9,  5'd9,  5'd9,  5'd9,  5'd9,  5'd10,
    5'd11, 5'd11, 5'd12, 5'd12, 5'd12, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14,
    5'd14, 5'd14, 5'd14, 5'd14, 5'd15, 5'd15, 5'd15, 5'd15, 5'd16, 5'd16,
    5'd16, 5'd16, 5'd17, 5'd17, 5'd17, 5'd17, 5'd18, 5'd19, 5'd19, 5'd20,
    5'd20, 5'd21, 5'd21, 5'd21
  };

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: hdl/cuc_decode.sv
// Codon decoder: case folding, base check and table lookup.
`timescale 1ns / 1ps
module cuc_decode (
  input  logic [7:0]          first_base,
  input  logic [7:0]          second_base,
  input  logic [7:0]          third_base,
  output cuc_pkg::codon_info_t info
);
  import cuc_pkg::*;

  logic [7:0] up [0:2];
  base_t      code [0:2];
  logic [2:0] ok;
  logic [5:0] key;
  logic [5:0] ref_idx;

  always_comb begin
    up[0] = fold_upper(first_base);
    up[1] = fold_upper(second_base);
    up[2] = fold_upper(third_base);
    for (int i = 0; i < 3; i++) begin
      ok[i]   = 1'b1;
      code[i] = BASE_A;
      case (up[i])
        8'h41:   code[i] = BASE_A;
        8'h43:   code[i] = BASE_C;
        8'h47:   code[i] = BASE_G;
        8'h54:   code[i] = BASE_T;
        default: ok[i]   = 1'b0;
      endcase
    end
    key     = {code[0], code[1], code[2]};
    ref_idx = CODON_REF[key];
    // drop the indices of anything that is not a clean codon
    info.recognized  = &ok;
    info.codon_index = (&ok) ? ref_idx : 6'd0;
    info.amino_index = (&ok) ? AMINO_OF[ref_idx] : 5'd0;
  end

endmodule

FILE: hdl/cuc_count_bank.sv
// Counter memory with valid bits, last-write forwarding and saturating update.
`timescale 1ns / 1ps
module cuc_count_bank #(
  parameter int DEPTH = cuc_pkg::CODON_COUNT,
  parameter int WIDTH = cuc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cuc_pkg::bank_ctl_t       ctl,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  import cuc_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic [AW-1:0]    addr_r;
  logic [WIDTH-1:0] raw_r;
  logic             raw_vld_r;
  logic             fwd_wr_r, fwd_clr_r;
  logic [AW-1:0]    fwd_addr_r;
  logic [WIDTH-1:0] fwd_data_r;
  logic [WIDTH-1:0] inc;

  // read port registered; write back the incremented entry
  always_ff @(posedge clk) begin
    if (ctl.upd_en) begin
      mem[addr_r] <= inc;
    end
    if (ctl.rd_en) begin
      raw_r     <= mem[rd_addr];
      raw_vld_r <= vld_r[rd_addr];
      addr_r    <= rd_addr;
    end
    if (ctl.upd_en) begin
      fwd_addr_r <= addr_r;
      fwd_data_r <= inc;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (ctl.clr_en) begin
      vld_nxt = '0;
    end else if (ctl.upd_en) begin
      vld_nxt[addr_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      fwd_wr_r  <= 1'b0;
      fwd_clr_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (ctl.clr_en) begin
        fwd_wr_r  <= 1'b0;
        fwd_clr_r <= 1'b1;
      end else if (ctl.upd_en) begin
        fwd_wr_r  <= 1'b1;
        fwd_clr_r <= 1'b0;
      end
    end
  end

  // the last write or clear may not have reached the read data yet
  always_comb begin
    if (fwd_clr_r) begin
      rd_data = '0;
    end else if (fwd_wr_r && fwd_addr_r == addr_r) begin
      rd_data = fwd_data_r;
    end else if (raw_vld_r) begin
      rd_data = raw_r;
    end else begin
      rd_data = '0;
    end
    inc = (&rd_data) ? rd_data : rd_data + WIDTH'(1);
  end

endmodule

FILE: hdl/codon_usage_counter.sv
// Top level of the codon usage counter: input decode, counter pipeline, output register.
`timescale 1ns / 1ps
// Codon usage counter. Each input transfer carries one operation: count a codon
// (three raw characters, folded to upper case), read a codon counter, read an
// amino-acid counter, or clear all counters and the position. Every transfer
// returns exactly one result transfer, in order. Throughput is one item per
// clock while the output does not stall. A result passes through stage 1 and
// the output register before it is offered. Codon and amino-acid counts live
// in two synchronous memories (64 and 22 entries). They are read when an item
// is accepted and written back as the item leaves stage 1, which waits while
// the output stalls. The single write in flight is forwarded to the next item
// so back-to-back counts of the same codon add up. Per-entry valid bits let
// clear and reset take effect with no clearing pass. Counters saturate at
// 2^COUNT_WIDTH-1 and positions at 2^POSITION_WIDTH-1; reads return the low 32
// bits of a counter. An unrecognized codon still takes a position but changes
// no counter. in_stall rises only while a result sits in the output register
// and out_stall holds it.
module codon_usage_counter #(
  parameter int COUNT_WIDTH    = cuc_pkg::COUNT_WIDTH_DEF,
  parameter int POSITION_WIDTH = cuc_pkg::POSITION_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cuc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cuc_pkg::out_item_t out_data
);
  import cuc_pkg::*;

  localparam int CAW = $clog2(CODON_COUNT);
  localparam int AAW = $clog2(AMINO_COUNT);

  codon_info_t               dec;
  logic                      in_acc;
  logic                      s1_adv;
  logic [POSITION_WIDTH-1:0] pos_cur;
  logic [POSITION_WIDTH-1:0] next_pos_r;
  logic                      idx_ok;
  logic [CAW-1:0]            codon_addr;
  logic [AAW-1:0]            amino_addr;
  bank_ctl_t                 codon_ctl, amino_ctl;
  logic [COUNT_WIDTH-1:0]    codon_cnt, amino_cnt;
  logic [63:0]               cnt_ext;
  logic [31:0]               pos_ext;

  // stage 1: item whose counters are being read and updated
  logic                      s1_v_r;
  op_t                       s1_op_r;
  logic                      s1_recog_r;
  logic [5:0]                s1_cidx_r;
  logic [4:0]                s1_aidx_r;
  logic [POSITION_WIDTH-1:0] s1_pos_r;
  logic                      s1_idx_ok_r;

  // output register
  logic                      out_v_r;
  out_item_t                 out_r, out_nxt;

  cuc_decode u_decode (
    .first_base  (in_data.first_base),
    .second_base (in_data.second_base),
    .third_base  (in_data.third_base),
    .info        (dec)
  );

  // Advance stage 1 whenever the output register is free or being emptied.
  assign s1_adv   = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && out_v_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // Position of this codon; a new sequence restarts numbering at zero.
  assign pos_cur = in_data.start_of_sequence ? '0 : next_pos_r;
  assign idx_ok  = in_data.table_index < 6'(AMINO_COUNT);

  // Read addresses: counting uses the decoded indices, reads use table_index.
  always_comb begin
    codon_addr = dec.codon_index;
    amino_addr = dec.amino_index;
    if (in_data.operation == OP_READ_CODON) begin
      codon_addr = in_data.table_index;
    end
    if (in_data.operation == OP_READ_AMINO) begin
      amino_addr = idx_ok ? in_data.table_index[AAW-1:0] : '0;
    end
  end

  // Writes and clears happen as the item leaves stage 1, so they stay in order.
  always_comb begin
    codon_ctl.rd_en  = in_acc;
    codon_ctl.upd_en = s1_adv && s1_op_r == OP_COUNT && s1_recog_r;
    codon_ctl.clr_en = s1_adv && s1_op_r == OP_CLEAR;
    amino_ctl        = codon_ctl;
  end

  cuc_count_bank #(
    .DEPTH (CODON_COUNT),
    .WIDTH (COUNT_WIDTH)
  ) u_codon_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (codon_ctl),
    .rd_addr (codon_addr),
    .rd_data (codon_cnt)
  );

  cuc_count_bank #(
    .DEPTH (AMINO_COUNT),
    .WIDTH (COUNT_WIDTH)
  ) u_amino_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (amino_ctl),
    .rd_addr (amino_addr),
    .rd_data (amino_cnt)
  );

  // Position counter: advance on every count, saturate, zero on clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_pos_r <= '0;
    end else if (in_acc) begin
      if (in_data.operation == OP_COUNT) begin
        next_pos_r <= (&pos_cur) ? pos_cur : pos_cur + POSITION_WIDTH'(1);
      end else if (in_data.operation == OP_CLEAR) begin
        next_pos_r <= '0;
      end
    end
  end

  // Stage 1 payload; fields the operation does not use are zeroed here.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= in_data.operation;
      s1_idx_ok_r <= idx_ok;
      if (in_data.operation == OP_COUNT) begin
        s1_recog_r <= dec.recognized;
        s1_cidx_r  <= dec.codon_index;
        s1_aidx_r  <= dec.amino_index;
        s1_pos_r   <= pos_cur;
      end else begin
        s1_recog_r <= 1'b0;
        s1_cidx_r  <= '0;
        s1_aidx_r  <= '0;
        s1_pos_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Build the result from stage 1 and the corrected counter values.
  always_comb begin
    cnt_ext = '0;
    case (s1_op_r)
      OP_READ_CODON: cnt_ext = 64'(codon_cnt);
      OP_READ_AMINO: cnt_ext = s1_idx_ok_r ? 64'(amino_cnt) : 64'd0;
      default:       cnt_ext = '0;
    endcase
    pos_ext                  = 32'(s1_pos_r);
    out_nxt.codon_recognized = s1_recog_r;
    out_nxt.codon_index      = s1_cidx_r;
    out_nxt.amino_acid_index = s1_aidx_r;
    out_nxt.position         = pos_ext[OUT_POS_WIDTH-1:0];
    out_nxt.count_value      = cnt_ext[OUT_COUNT_WIDTH-1:0];
    out_nxt.index_valid      = !(s1_op_r == OP_READ_AMINO && !s1_idx_ok_r);
  end

  // Hold the result while the consumer stalls.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
